// ===== src/bsep_pkg.sv =====
package bsep_pkg;

  // fixed field widths
  localparam int COORD_W   = 12;
  localparam int VAL_W     = 32;
  localparam int STEP_W    = 31;
  localparam int CNT_W     = 16;
  localparam int COLOUR_W  = 17;
  localparam int PROD_W    = 64;
  localparam int CFG_IDX_W = 3;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_RE   = 3'd0,
    REG_ORIGIN_IM   = 3'd1,
    REG_STEP_RE     = 3'd2,
    REG_STEP_IM     = 3'd3,
    REG_ITER_LIMIT  = 3'd4,
    REG_COLOUR_MODE = 3'd5,
    REG_PALETTE     = 3'd6
  } reg_idx_e;

  // register reset values
  localparam logic signed [VAL_W-1:0] RST_ORIGIN_RE = -32'sd268435456;
  localparam logic signed [VAL_W-1:0] RST_ORIGIN_IM = 32'sd268435456;
  localparam logic [STEP_W-1:0]       RST_STEP      = 31'd262144;
  localparam logic [CNT_W-1:0]        RST_LIMIT     = 16'd256;
  localparam logic [CNT_W-1:0]        RST_PALETTE   = 16'd256;

  typedef struct packed {
    logic signed [VAL_W-1:0] origin_re;
    logic signed [VAL_W-1:0] origin_im;
    logic [STEP_W-1:0]       step_re;
    logic [STEP_W-1:0]       step_im;
    logic [CNT_W-1:0]        iteration_limit;
    logic                    colour_mode;
    logic [CNT_W-1:0]        palette_size;
  } cfg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CADD,
    ST_SQR,
    ST_UPD,
    ST_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_coord;
    logic add_coord;
    logic mul_z;
    logic upd_z;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic limit_zero;
    logic escape;
    logic last_iter;
  } stat_t;

endpackage

// ===== src/bsep_ctrl.sv =====
module bsep_ctrl
  import bsep_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state and output slot registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CMUL;
        end
      end
      ST_CMUL: begin
        cmd_o.mul_coord = 1'b1;
        state_d         = ST_CADD;
      end
      ST_CADD: begin
        cmd_o.add_coord = 1'b1;
        state_d         = stat_i.limit_zero ? ST_FIN : ST_SQR;
      end
      ST_SQR: begin
        cmd_o.mul_z = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd_z = 1'b1;
        state_d     = (stat_i.escape || stat_i.last_iter) ? ST_FIN : ST_SQR;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result slot: filled on emit, drained by the sink
  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // a taken pixel keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input open right after accept");

  // an emitted result shows up on the next cycle
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_o)
    else $error("emitted result not presented");

  // an escape ends the iteration run
  a_escape_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && stat_i.escape) |=> (state_q == ST_FIN))
    else $error("escape did not finish pixel");

endmodule

// ===== src/bsep_datapath.sv =====
module bsep_datapath
  import bsep_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 27
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic [COORD_W-1:0]  pixel_col_i,
  input  logic [COORD_W-1:0]  pixel_row_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output logic [COLOUR_W-1:0] colour_index_o,
  output logic                inside_set_o
);

  localparam int CB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] CMASK = COORD_W'((1 << CB) - 1);
  localparam logic [PROD_W-1:0]  FOUR  = PROD_W'(4) << FRAC_BITS;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(32'sh7fffffff);
    lo = -(PROD_W'(64'sh80000000));
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

  logic [COORD_W-1:0]      col_q, row_q;
  logic signed [VAL_W-1:0] cr_q, ci_q, zr_q, zi_q;
  logic [PROD_W-1:0]       p0_q, p1_q, p2_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    inside_q;
  logic [COLOUR_W-1:0]     colour_q;
  logic                    out_inside_q;

  // magnitudes of z
  logic [VAL_W-1:0] ar, ai;
  assign ar = zr_q[VAL_W-1] ? VAL_W'(-zr_q) : VAL_W'(zr_q);
  assign ai = zi_q[VAL_W-1] ? VAL_W'(-zi_q) : VAL_W'(zi_q);

  // shared multipliers: coordinate products, then the squarer passes
  logic [VAL_W-1:0] m0a, m0b, m1a, m1b;
  always_comb begin
    if (cmd_i.mul_coord) begin
      m0a = VAL_W'(col_q);
      m0b = VAL_W'(cfg_i.step_re);
      m1a = VAL_W'(row_q);
      m1b = VAL_W'(cfg_i.step_im);
    end else begin
      m0a = ar;
      m0b = ar;
      m1a = ai;
      m1b = ai;
    end
  end

  // truncated squares and cross term
  logic [PROD_W-1:0]        sr, si, xprod;
  logic signed [PROD_W-1:0] zr_sum, zi_sum, cr_sum, ci_sum;
  assign sr     = p0_q >> FRAC_BITS;
  assign si     = p1_q >> FRAC_BITS;
  assign xprod  = p2_q >> (FRAC_BITS - 1);
  assign zr_sum = $signed(sr) - $signed(si) + PROD_W'(cr_q);
  assign zi_sum = $signed(xprod) + PROD_W'(ci_q);
  assign cr_sum = PROD_W'(cfg_i.origin_re) + $signed(p0_q);
  assign ci_sum = PROD_W'(cfg_i.origin_im) - $signed(p1_q);

  assign stat_o.escape     = (sr + si) > FOUR;
  assign stat_o.last_iter  = ({1'b0, cnt_q} + 17'd1) == {1'b0, cfg_i.iteration_limit};
  assign stat_o.limit_zero = (cfg_i.iteration_limit == '0);

  // quadrant offset of the last z
  logic [CNT_W+1:0]    p3;
  logic [CNT_W-1:0]    offset;
  logic [COLOUR_W-1:0] colour;
  assign p3 = {2'b00, cfg_i.palette_size} + {1'b0, cfg_i.palette_size, 1'b0};
  always_comb begin
    if (zr_q > 0 && zi_q > 0) begin
      offset = CNT_W'(1);
    end else if (zr_q <= 0 && zi_q > 0) begin
      offset = cfg_i.palette_size >> 2;
    end else if (zr_q <= 0 && zi_q < 0) begin
      offset = cfg_i.palette_size >> 1;
    end else begin
      offset = p3[CNT_W+1:2];
    end
  end
  assign colour = {1'b0, cnt_q} + (cfg_i.colour_mode ? {1'b0, offset} : '0);

  // pixel, c, z, products and the emitted result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= pixel_col_i & CMASK;
      row_q <= pixel_row_i & CMASK;
      zr_q  <= '0;
      zi_q  <= '0;
    end
    if (cmd_i.mul_coord || cmd_i.mul_z) begin
      p0_q <= PROD_W'(m0a) * PROD_W'(m0b);
      p1_q <= PROD_W'(m1a) * PROD_W'(m1b);
    end
    if (cmd_i.mul_z) begin
      p2_q <= PROD_W'(ar) * PROD_W'(ai);
    end
    if (cmd_i.add_coord) begin
      cr_q <= sat32(cr_sum);
      ci_q <= sat32(ci_sum);
    end
    if (cmd_i.upd_z && !stat_o.escape) begin
      zr_q <= sat32(zr_sum);
      zi_q <= sat32(zi_sum);
    end
    if (cmd_i.emit) begin
      colour_q     <= colour;
      out_inside_q <= inside_q;
    end
  end

  // iteration count and inside flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      inside_q <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q    <= '0;
      inside_q <= 1'b1;
    end else if (cmd_i.upd_z) begin
      if (stat_o.escape) begin
        inside_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  assign colour_index_o = colour_q;
  assign inside_set_o   = out_inside_q;

  // an update pass only runs below the limit
  a_cnt_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd_z |-> (cnt_q < cfg_i.iteration_limit))
    else $error("iteration past limit");

  // the inside flag drops only on an escaping update
  a_inside_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(inside_q) |-> $past(cmd_i.upd_z))
    else $error("inside flag cleared outside update");

endmodule

// ===== src/burning_ship_escape_pixel_top.sv =====
// burning ship escape-time pixel engine, one pixel at a time
// each squarer pass runs on the shared multiplier bank: multiply, then add/compare/saturate
// reset: asynchronous active low, config registers return to defaults, no result pending
module burning_ship_escape_pixel_top
  import bsep_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 27
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave stream: [11:0] pixel_col, [23:12] pixel_row
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,
  // master stream: [16:0] colour_index, zero padded
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,
  // [0] inside_set
  output logic                 m_axis_tuser,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VAL_W-1:0]     cfg_data_i
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic [COLOUR_W-1:0] colour_index;

  assign cfg_ready_o = 1'b1;

  // config register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_re       <= RST_ORIGIN_RE;
      cfg_q.origin_im       <= RST_ORIGIN_IM;
      cfg_q.step_re         <= RST_STEP;
      cfg_q.step_im         <= RST_STEP;
      cfg_q.iteration_limit <= RST_LIMIT;
      cfg_q.colour_mode     <= 1'b0;
      cfg_q.palette_size    <= RST_PALETTE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_RE:   cfg_q.origin_re       <= cfg_data_i;
        REG_ORIGIN_IM:   cfg_q.origin_im       <= cfg_data_i;
        REG_STEP_RE:     cfg_q.step_re         <= cfg_data_i[STEP_W-1:0];
        REG_STEP_IM:     cfg_q.step_im         <= cfg_data_i[STEP_W-1:0];
        REG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_data_i[CNT_W-1:0];
        REG_COLOUR_MODE: cfg_q.colour_mode     <= cfg_data_i[0];
        REG_PALETTE:     cfg_q.palette_size    <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  bsep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic
  bsep_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pixel_col_i    (s_axis_tdata[11:0]),
    .pixel_row_i    (s_axis_tdata[23:12]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .colour_index_o (colour_index),
    .inside_set_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, colour_index};

endmodule
